// ----- rtl/core/ffba_pkg.sv -----
// Package for the first-fit block allocator: field widths, opcodes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package ffba_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CFG_W     = 5;
  // wide enough for any block count up to 256 and the count itself
  localparam int unsigned LIMIT_W   = 9;
  localparam int unsigned IN_BITS   = OP_W + IDX_W + SIZE_W;
  localparam int unsigned OUT_BITS  = 1 + IDX_W + SIZE_W;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic start;    // item accepted: capture request, zero the result
    logic load_we;  // write the beat's size into the size table
    logic clear;    // drop every taken mark
    logic issue;    // read the next table entry
    logic grant;    // take the entry under compare
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic hit;
    logic all_issued;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/ffba_dp.sv -----
// Datapath of the first-fit block allocator: size table, taken marks,
// scan counter, compare stage and result hold. Depends on ffba_pkg.
`default_nettype none

module ffba_dp #(
  parameter int unsigned NUM_BLOCKS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ffba_pkg::cmd_t                cmd_i,
  input  wire logic [ffba_pkg::IDX_W-1:0]    block_index_i,
  input  wire logic [ffba_pkg::SIZE_W-1:0]   size_value_i,
  input  wire logic [ffba_pkg::CFG_W-1:0]    blocks_in_use_i,
  output ffba_pkg::status_t                  status_o,
  output logic                               res_granted_o,
  output logic [ffba_pkg::IDX_W-1:0]         res_block_o,
  output logic [ffba_pkg::SIZE_W-1:0]        res_leftover_o
);

  localparam int unsigned IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned LW = ffba_pkg::LIMIT_W;

  logic [ffba_pkg::SIZE_W-1:0] sizes_q [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]       taken_q;
  logic [ffba_pkg::SIZE_W-1:0] size_q;
  logic [IW-1:0]               scan_q;
  logic                        all_issued_q;
  logic [ffba_pkg::SIZE_W-1:0] rd_q;
  logic [IW-1:0]               rd_idx_q;
  logic                        rd_vld_q;
  logic                        res_granted_q;
  logic [ffba_pkg::IDX_W-1:0]  res_block_q;
  logic [ffba_pkg::SIZE_W-1:0] res_leftover_q;

  logic [LW-1:0] cfg_ext;
  logic [LW-1:0] limit;
  logic [LW-1:0] wr_ext;
  logic [LW-1:0] rd_idx_ext;
  logic          wr_ok;
  logic          scan_last;
  logic          hit;

  always_comb begin
    cfg_ext    = LW'(blocks_in_use_i);
    limit      = (cfg_ext > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : cfg_ext;
    scan_last  = ((LW'(scan_q) + LW'(1)) == limit);
    wr_ext     = LW'(block_index_i);
    wr_ok      = (wr_ext < LW'(NUM_BLOCKS));
    rd_idx_ext = LW'(rd_idx_q);
    hit        = rd_vld_q && !taken_q[rd_idx_q] && (size_q <= rd_q);
  end

  assign status_o.limit_zero = (limit == '0);
  assign status_o.hit        = hit;
  assign status_o.all_issued = all_issued_q;

  // size table: one write port for loads, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && wr_ok) begin
      sizes_q[wr_ext[IW-1:0]] <= size_value_i;
    end
    if (cmd_i.issue) begin
      rd_q     <= sizes_q[scan_q];
      rd_idx_q <= scan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q      <= '0;
      scan_q       <= '0;
      all_issued_q <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.clear) begin
        taken_q <= '0;
      end else if (cmd_i.grant) begin
        taken_q[rd_idx_q] <= 1'b1;
      end
      if (cmd_i.start) begin
        scan_q       <= '0;
        all_issued_q <= 1'b0;
      end else if (cmd_i.issue) begin
        scan_q <= scan_q + IW'(1);
        if (scan_last) begin
          all_issued_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      size_q         <= size_value_i;
      res_block_q    <= '0;
      res_leftover_q <= '0;
    end else if (cmd_i.grant) begin
      res_block_q    <= rd_idx_ext[ffba_pkg::IDX_W-1:0];
      res_leftover_q <= rd_q - size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_granted_q <= 1'b0;
    end else if (cmd_i.start) begin
      res_granted_q <= 1'b0;
    end else if (cmd_i.grant) begin
      res_granted_q <= 1'b1;
    end
  end

  assign res_granted_o  = res_granted_q;
  assign res_block_o    = res_block_q;
  assign res_leftover_o = res_leftover_q;

endmodule

`default_nettype wire

// ----- rtl/core/ffba_ctrl.sv -----
// Controller of the first-fit block allocator: accepts a beat, runs the
// table scan for requests and hands the result on. Depends on ffba_pkg.
`default_nettype none

module ffba_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ffba_pkg::OP_W-1:0]   opcode_i,
  input  wire ffba_pkg::status_t           status_i,
  input  wire logic                        out_free_i,
  output logic                             push_o,
  output ffba_pkg::cmd_t                   cmd_o
);

  ffba_pkg::state_e state_q, state_d;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    cmd_o      = '0;
    accept     = 1'b0;
    case (state_q)
      ffba_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (accept) begin
          cmd_o.start   = 1'b1;
          cmd_o.load_we = (opcode_i == ffba_pkg::OP_LOAD);
          cmd_o.clear   = (opcode_i == ffba_pkg::OP_CLEAR);
          if ((opcode_i == ffba_pkg::OP_REQUEST) && !status_i.limit_zero) begin
            state_d = ffba_pkg::ST_SCAN;
          end else begin
            state_d = ffba_pkg::ST_PUSH;
          end
        end
      end
      ffba_pkg::ST_SCAN: begin
        // reads run one entry ahead of the compare
        if (status_i.hit) begin
          cmd_o.grant = 1'b1;
          state_d     = ffba_pkg::ST_PUSH;
        end else if (status_i.all_issued) begin
          state_d = ffba_pkg::ST_PUSH;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ffba_pkg::ST_PUSH: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = ffba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: stream ports, configuration
// register and output register. Depends on ffba_pkg, ffba_ctrl, ffba_dp.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      opcode, block_index, size_value
//   m_axis    out  m_axis_tvalid/tready      granted, granted_block, leftover
//   cfg       in   cfg_valid/cfg_ready       blocks_in_use
//
// One beat at a time. Load, clear and unused opcodes go straight from accept to
// the result push; a request runs the one-entry-per-cycle scan over L entries,
// L = min(blocks_in_use, NUM_BLOCKS), through the single read port of the size
// table and stops at the first fit; with L = 0 it is refused without a scan.
// A held result in the output register does not stop the next beat being
// accepted; it only delays the hand-off.
// Reset clears the taken marks, the state and blocks_in_use; sizes need loading.
`default_nettype none

module first_fit_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [1:0] opcode, [5:2] block_index, [21:6] size_value, [23:22] zero
  input  wire logic [ffba_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [0] granted, [4:1] granted_block, [20:5] leftover, [23:21] zero
  output logic [ffba_pkg::M_TDATA_W-1:0]        m_axis_tdata_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [ffba_pkg::CFG_W-1:0]       cfg_data_i
);

  logic [ffba_pkg::OP_W-1:0]   opcode;
  logic [ffba_pkg::IDX_W-1:0]  block_index;
  logic [ffba_pkg::SIZE_W-1:0] size_value;

  logic [ffba_pkg::CFG_W-1:0]    blocks_in_use_q;
  logic                          out_vld_q;
  logic [ffba_pkg::OUT_BITS-1:0] out_data_q;

  ffba_pkg::cmd_t              cmd;
  ffba_pkg::status_t           status;
  logic                        push;
  logic                        out_free;
  logic                        res_granted;
  logic [ffba_pkg::IDX_W-1:0]  res_block;
  logic [ffba_pkg::SIZE_W-1:0] res_leftover;

  assign opcode      = s_axis_tdata_i[ffba_pkg::OP_W-1:0];
  assign block_index = s_axis_tdata_i[ffba_pkg::OP_W +: ffba_pkg::IDX_W];
  assign size_value  = s_axis_tdata_i[ffba_pkg::OP_W + ffba_pkg::IDX_W +: ffba_pkg::SIZE_W];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q <= '0;
    end else if (cfg_valid_i) begin
      blocks_in_use_q <= cfg_data_i;
    end
  end

  assign out_free = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= {res_leftover, res_block, res_granted};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = ffba_pkg::M_TDATA_W'(out_data_q);

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .opcode_i   (opcode),
    .status_i   (status),
    .out_free_i (out_free),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  ffba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .block_index_i   (block_index),
    .size_value_i    (size_value),
    .blocks_in_use_i (blocks_in_use_q),
    .status_o        (status),
    .res_granted_o   (res_granted),
    .res_block_o     (res_block),
    .res_leftover_o  (res_leftover)
  );

endmodule

`default_nettype wire

// ----- dv/first_fit_block_allocator_checker.sv -----
// Checker for the first-fit block allocator: watches the input, result and
// configuration channels, predicts each grant and compares it field by field.
// Depends on ffba_pkg.
module first_fit_block_allocator_checker #(
  parameter int unsigned NUM_BLOCKS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  input  wire logic                           s_axis_tready_i,
  // [1:0] opcode, [5:2] block_index, [21:6] size_value, [23:22] zero
  input  wire logic [ffba_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input  wire logic                           m_axis_tvalid_i,
  input  wire logic                           m_axis_tready_i,
  // [0] granted, [4:1] granted_block, [20:5] leftover, [23:21] zero
  input  wire logic [ffba_pkg::M_TDATA_W-1:0] m_axis_tdata_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic                           cfg_ready_i,
  input  wire logic [ffba_pkg::CFG_W-1:0]     cfg_data_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic                        granted;
    logic [ffba_pkg::IDX_W-1:0]  blk;
    logic [ffba_pkg::SIZE_W-1:0] leftover;
  } grant_t;

  logic [ffba_pkg::SIZE_W-1:0] block_size [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]       taken;
  logic [ffba_pkg::CFG_W-1:0]  blocks_in_use;
  grant_t                      expected_grants [$];
  int unsigned                 mismatches;

  // Applies one beat to the shadow table and returns the grant it should produce.
  function automatic grant_t first_fit(input logic [ffba_pkg::OP_W-1:0] op,
                                       input logic [ffba_pkg::IDX_W-1:0] idx,
                                       input logic [ffba_pkg::SIZE_W-1:0] size);
    grant_t      g;
    int unsigned span;
    g = '0;
    span = (blocks_in_use > NUM_BLOCKS) ? NUM_BLOCKS : blocks_in_use;
    case (op)
      ffba_pkg::OP_LOAD: begin
        if (idx < NUM_BLOCKS) block_size[idx] = size;
      end
      ffba_pkg::OP_CLEAR: begin
        taken = '0;
      end
      ffba_pkg::OP_REQUEST: begin
        for (int j = 0; j < span; j++) begin
          if (!g.granted && !taken[j] && size <= block_size[j]) begin
            taken[j]   = 1'b1;
            g.granted  = 1'b1;
            g.blk      = j[ffba_pkg::IDX_W-1:0];
            g.leftover = block_size[j] - size;
          end
        end
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    grant_t                      got;
    grant_t                      want;
    logic [ffba_pkg::OP_W-1:0]   in_op;
    logic [ffba_pkg::IDX_W-1:0]  in_idx;
    logic [ffba_pkg::SIZE_W-1:0] in_size;
    if (!rst_ni) begin
      taken         = '0;
      blocks_in_use = '0;
      expected_grants.delete();
      mismatches    = 0;
    end else begin
      // results first: a beat accepted at this edge cannot already be answered
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.granted  = m_axis_tdata_i[0];
        got.blk      = m_axis_tdata_i[1 +: ffba_pkg::IDX_W];
        got.leftover = m_axis_tdata_i[1 + ffba_pkg::IDX_W +: ffba_pkg::SIZE_W];
        if (expected_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result granted=%0d block=%0d leftover=%0d",
                     $time, got.granted, got.blk, got.leftover);
        end else begin
          want = expected_grants.pop_front();
          if (got.granted !== want.granted || got.blk !== want.blk ||
              got.leftover !== want.leftover) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: result mismatch: expected granted=%0d block=%0d leftover=%0d,%s",
                       $time, want.granted, want.blk, want.leftover,
                       $sformatf(" got granted=%0d block=%0d leftover=%0d",
                                 got.granted, got.blk, got.leftover));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) blocks_in_use = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        in_op   = s_axis_tdata_i[ffba_pkg::OP_W-1:0];
        in_idx  = s_axis_tdata_i[ffba_pkg::OP_W +: ffba_pkg::IDX_W];
        in_size = s_axis_tdata_i[ffba_pkg::OP_W + ffba_pkg::IDX_W +: ffba_pkg::SIZE_W];
        expected_grants.push_back(first_fit(in_op, in_idx, in_size));
      end
    end
    fail_count_o = mismatches;
    pending_o    = expected_grants.size();
  end

endmodule

// ----- dv/first_fit_block_allocator_tb.sv -----
// Testbench top for the first-fit block allocator: clock, reset, stimulus,
// receiver back-pressure and verdict. Depends on ffba_pkg, the block and
// first_fit_block_allocator_checker.
module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_BLOCKS      = 16;
  localparam int unsigned RANDOM_ITEMS    = 1700;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned SETTLE          = NUM_BLOCKS + 8;
  localparam int unsigned HOLD_OFF_AT     = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam logic [ffba_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [ffba_pkg::CFG_W-1:0] FIXED_SETTINGS [5] =
    '{5'd31, 5'd1, 5'd0, 5'd16, 5'd17};

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  // [1:0] opcode, [5:2] block_index, [21:6] size_value, [23:22] zero
  logic [ffba_pkg::S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  // [0] granted, [4:1] granted_block, [20:5] leftover, [23:21] zero
  logic [ffba_pkg::M_TDATA_W-1:0] m_axis_tdata_o;
  logic                           cfg_valid_i     = 1'b0;
  logic                           cfg_ready_o;
  logic [ffba_pkg::CFG_W-1:0]     cfg_data_i      = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sent_items = 0;
  int unsigned cycles     = 0;
  bit          calm       = 1'b0;
  logic        hold_off   = 1'b0;

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  first_fit_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  first_fit_block_allocator_checker #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // kept small so requests and block sizes overlap; extremes now and then
  function automatic logic [ffba_pkg::SIZE_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return ffba_pkg::SIZE_W'($urandom_range(0, 4095));
    if (roll < 90) return ffba_pkg::SIZE_W'($urandom_range(0, 65535));
    if (roll < 95) return '0;
    return '1;
  endfunction

  // Called at a clock edge; returns at the edge where the beat is taken.
  task automatic put_item(input logic [ffba_pkg::OP_W-1:0] op,
                          input logic [ffba_pkg::IDX_W-1:0] idx,
                          input logic [ffba_pkg::SIZE_W-1:0] size);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, size, idx, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_items++;
  endtask

  // Drains the block before touching the register.
  task automatic write_blocks_in_use(input logic [ffba_pkg::CFG_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("first_fit_block_allocator_tb: FAIL");
    $finish;
  end

  initial begin : sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall != 0) stall--;
      else if (!calm && $urandom_range(0, 2) == 0) stall = pick_gap();
      m_axis_tready_i <= rst_ni && !hold_off && stall == 0;
    end
  end

  // one long receiver hold-off mid-run so the block backs up onto its input
  initial begin : pressure
    wait (sent_items >= HOLD_OFF_AT);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    int unsigned                quota;
    int unsigned                roll;
    logic [ffba_pkg::CFG_W-1:0] setting;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing in use yet: refused without touching the table
    put_item(ffba_pkg::OP_REQUEST, '0, '0);
    for (int b = 0; b < NUM_BLOCKS; b++)
      put_item(ffba_pkg::OP_LOAD, ffba_pkg::IDX_W'(b),
               (b == 0) ? 16'd100 : (b == 1) ? 16'd0 :
               (b == 2) ? 16'hFFFF : ffba_pkg::SIZE_W'(b * 997));
    write_blocks_in_use(5'd16);
    put_item(ffba_pkg::OP_REQUEST, '0, 16'hFFFF);  // only the full-size block fits
    put_item(ffba_pkg::OP_REQUEST, '1, '0);        // lowest free block wins
    put_item(ffba_pkg::OP_REQUEST, '0, '0);        // zero-size block, no leftover
    put_item(ffba_pkg::OP_REQUEST, '0, 16'hFFFF);  // full-size block already taken
    put_item(OP_UNUSED, '1, 16'hFFFF);
    put_item(ffba_pkg::OP_CLEAR, '1, '1);
    put_item(ffba_pkg::OP_REQUEST, '0, 16'd101);

    for (int p = 0; p < PHASES; p++) begin
      setting = (p < 5) ? FIXED_SETTINGS[p] : ffba_pkg::CFG_W'($urandom_range(2, 15));
      write_blocks_in_use(setting);
      calm  = ($urandom_range(0, 3) == 0);
      quota = sent_items + RANDOM_ITEMS / PHASES;
      while (sent_items < quota) begin
        // a batch: usually a fresh clear, a few reloads, then a run of requests
        if ($urandom_range(0, 9) != 0)
          put_item(ffba_pkg::OP_CLEAR, ffba_pkg::IDX_W'($urandom), pick_size());
        repeat ($urandom_range(0, 3))
          put_item(ffba_pkg::OP_LOAD, ffba_pkg::IDX_W'($urandom), pick_size());
        repeat ($urandom_range(1, 20)) begin
          roll = $urandom_range(0, 99);
          if (roll < 85)
            put_item(ffba_pkg::OP_REQUEST, ffba_pkg::IDX_W'($urandom), pick_size());
          else if (roll < 92)
            put_item(ffba_pkg::OP_LOAD, ffba_pkg::IDX_W'($urandom), pick_size());
          else if (roll < 96)
            put_item(OP_UNUSED, ffba_pkg::IDX_W'($urandom), pick_size());
          else
            put_item(ffba_pkg::OP_CLEAR, ffba_pkg::IDX_W'($urandom), pick_size());
        end
      end
    end

    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("first_fit_block_allocator_tb: PASS");
    end else begin
      $display("first_fit_block_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- first_fit_block_allocator.f -----
rtl/core/ffba_pkg.sv
rtl/core/ffba_dp.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator.sv
dv/first_fit_block_allocator_checker.sv
dv/first_fit_block_allocator_tb.sv
